// ----- hdl/utf16_to_utf8_transcoder_unit_defines.svh -----
// Assertion macros shared by the transcoder checker.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/utt_pkg.sv -----
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
    localparam logic [15:0] LIMIT_ONE_BYTE  = 16'h0080;
    localparam logic [15:0] LIMIT_TWO_BYTE  = 16'h0800;
    localparam logic [10:0] SUPP_OFFSET_HI  = 11'h040;   // 0x10000 >> 10

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ONE,
        KIND_TWO,
        KIND_THREE,
        KIND_FOUR
    } kind_t;

    // One classified unit: optional flushed surrogate, main encoding, terminator.
    typedef struct packed {
        logic        flush;
        logic [9:0]  hi_bits;
        kind_t       kind;
        logic [15:0] unit;
        logic        term;
    } job_t;

endpackage

// ----- hdl/utt_front.sv -----
// Front end: accepts code units, tracks surrogate state and classifies each unit.
module utt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [15:0]   code_unit,
    input  logic          last_unit,
    input  logic          q_full,
    output logic          q_push,
    output utt_pkg::job_t q_job
);
    import utt_pkg::*;

    logic       pending_reg, pending_next;
    logic [9:0] hi_reg, hi_next;
    logic       after_term_reg, after_term_next;
    logic       accept;
    logic       is_low_surr;
    logic       is_high_surr;
    job_t       job;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign is_low_surr  = (code_unit >= SURR_LOW_FIRST) && (code_unit <= SURR_LOW_LAST);
    assign is_high_surr = (code_unit >= SURR_HIGH_FIRST) && (code_unit <= SURR_HIGH_LAST);

    always_comb
    begin
        pending_next    = pending_reg;
        hi_next         = hi_reg;
        after_term_next = after_term_reg;
        job.flush       = 1'b0;
        job.hi_bits     = hi_reg;
        job.kind        = KIND_NONE;
        job.unit        = code_unit;
        job.term        = 1'b0;

        if (accept)
        begin
            priority if (after_term_reg)
            begin
                // drop units until the end of the string
                if (last_unit)
                begin
                    after_term_next = 1'b0;
                end
            end
            else if (code_unit == 16'd0)
            begin
                job.flush       = pending_reg;
                job.term        = 1'b1;
                pending_next    = 1'b0;
                hi_next         = '0;
                after_term_next = !last_unit;
            end
            else if (pending_reg && is_low_surr)
            begin
                job.kind     = KIND_FOUR;
                job.term     = last_unit;
                pending_next = 1'b0;
                hi_next      = '0;
            end
            else
            begin
                job.flush    = pending_reg;
                job.term     = last_unit;
                pending_next = 1'b0;
                hi_next      = '0;
                priority if (code_unit < LIMIT_ONE_BYTE)
                begin
                    job.kind = KIND_ONE;
                end
                else if (code_unit < LIMIT_TWO_BYTE)
                begin
                    job.kind = KIND_TWO;
                end
                else if (is_high_surr && !last_unit)
                begin
                    // hold until the next unit shows whether it pairs
                    pending_next = 1'b1;
                    hi_next      = code_unit[9:0];
                end
                else
                begin
                    job.kind = KIND_THREE;
                end
            end
        end
    end

    assign q_push = accept && (job.flush || job.term || (job.kind != KIND_NONE));
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            hi_reg         <= '0;
            after_term_reg <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            hi_reg         <= hi_next;
            after_term_reg <= after_term_next;
        end
    end

endmodule

// ----- hdl/utt_queue.sv -----
// Short job queue between the front end and the byte emitter.
module utt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  utt_pkg::job_t wr_job,
    output logic          q_full,
    input  logic          rd_en,
    output utt_pkg::job_t rd_job,
    output logic          q_empty
);
    import utt_pkg::*;

    job_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/utt_back.sv -----
// Back end: walks the job at the queue head and emits one UTF-8 byte per cycle while the output is not stalled.
module utt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  utt_pkg::job_t q_job,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    utf8_byte,
    output logic          last_byte
);
    import utt_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [15:0] flush_unit;
    logic [7:0]  flush_b [3];
    logic [7:0]  main_b [4];
    logic [2:0]  flush_cnt;
    logic [2:0]  main_cnt;
    logic [2:0]  total;
    logic [2:0]  rel;
    logic [20:0] supp;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        advance;

    assign flush_unit = SURR_HIGH_FIRST | {6'd0, q_job.hi_bits};
    assign flush_b[0] = LEAD_THREE | {4'd0, flush_unit[15:12]};
    assign flush_b[1] = CONT_MARK | {2'd0, flush_unit[11:6]};
    assign flush_b[2] = CONT_MARK | {2'd0, flush_unit[5:0]};

    // supplementary code point: 0x10000 + (high << 10) + low offset
    assign supp = {SUPP_OFFSET_HI + {1'b0, q_job.hi_bits}, q_job.unit[9:0]};

    always_comb
    begin
        main_b[0] = 8'd0;
        main_b[1] = 8'd0;
        main_b[2] = 8'd0;
        main_b[3] = 8'd0;
        main_cnt  = 3'd0;
        unique case (q_job.kind)
            KIND_ONE:
            begin
                main_b[0] = q_job.unit[7:0];
                main_cnt  = 3'd1;
            end
            KIND_TWO:
            begin
                main_b[0] = LEAD_TWO | {3'd0, q_job.unit[10:6]};
                main_b[1] = CONT_MARK | {2'd0, q_job.unit[5:0]};
                main_cnt  = 3'd2;
            end
            KIND_THREE:
            begin
                main_b[0] = LEAD_THREE | {4'd0, q_job.unit[15:12]};
                main_b[1] = CONT_MARK | {2'd0, q_job.unit[11:6]};
                main_b[2] = CONT_MARK | {2'd0, q_job.unit[5:0]};
                main_cnt  = 3'd3;
            end
            KIND_FOUR:
            begin
                main_b[0] = LEAD_FOUR | {5'd0, supp[20:18]};
                main_b[1] = CONT_MARK | {2'd0, supp[17:12]};
                main_b[2] = CONT_MARK | {2'd0, supp[11:6]};
                main_b[3] = CONT_MARK | {2'd0, supp[5:0]};
                main_cnt  = 3'd4;
            end
            default:
            begin
                main_cnt = 3'd0;
            end
        endcase
    end

    assign flush_cnt = q_job.flush ? 3'd3 : 3'd0;
    assign total     = flush_cnt + main_cnt + {2'd0, q_job.term};
    assign rel       = idx_reg - flush_cnt;

    always_comb
    begin
        cur_last = 1'b0;
        priority if (idx_reg < flush_cnt)
        begin
            cur_byte = flush_b[idx_reg[1:0]];
        end
        else if (rel < main_cnt)
        begin
            cur_byte = main_b[rel[1:0]];
        end
        else
        begin
            cur_byte = 8'd0;
            cur_last = 1'b1;
        end
    end

    // load the output register whenever it is free or being drained
    assign advance = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = advance && (idx_reg == (total - 3'd1));

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = q_pop ? 3'd0 : (idx_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign utf8_byte = out_byte_reg;
    assign last_byte = out_last_reg;

endmodule

// ----- hdl/utf16_to_utf8_transcoder_unit.sv -----
// UTF-16 to UTF-8 transcoder: top level.
//
// Input channel: drive code_unit/last_unit and raise push; a transaction
// happens on a rising edge with push high and full low. Output channel: while
// empty is low, utf8_byte/last_byte show the oldest byte; pop takes it.
// last_byte marks the NUL terminator that ends each string (a zero unit or a
// unit flagged last_unit). A high surrogate without last_unit is held until
// the next unit. The front end classifies one unit per cycle into a
// four-entry job queue; the back end emits one byte per cycle from the job
// at the queue head while pop keeps the output register draining, so a unit
// yields zero to seven output bytes (none for a held or dropped unit,
// typically one to three). Units are accepted every cycle while the queue
// has room. A unit's first byte passes the job queue and then the output
// register. Reset empties the queue and output register and clears the held
// surrogate and drop-after-terminator state. When the receiver stalls, the
// output byte holds, the emitter stops, the queue fills and full rises.
module utf16_to_utf8_transcoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  utf8_byte,
    output logic        last_byte
);
    import utt_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t wr_job;
    job_t rd_job;

    utt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (wr_job)
    );

    utt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (wr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (rd_job),
        .q_empty (q_empty)
    );

    utt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (rd_job),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .utf8_byte (utf8_byte),
        .last_byte (last_byte)
    );

endmodule

// ----- hdl/utt_checker.sv -----
// Port-level checker for the transcoder, bound to the top level.
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module utt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  utf8_byte,
    input logic        last_byte
);

    // hold a stalled output byte
    `UTT_ASSERT_NEXT(a_out_hold, (!empty && !pop), (!empty && $stable(utf8_byte) && $stable(last_byte)), "output changed while stalled")

    // terminator is always a NUL byte
    `UTT_ASSERT_NOW(a_term_nul, (!empty && last_byte), (utf8_byte == 8'd0), "last_byte on non-NUL byte")

    // a multi-byte lead byte is followed at once by a continuation byte
    `UTT_ASSERT_NEXT(a_lead_cont, (!empty && pop && (utf8_byte[7:6] == 2'b11)), (!empty && (utf8_byte[7:6] == 2'b10) && !last_byte), "lead byte not followed by continuation")

endmodule

bind utf16_to_utf8_transcoder_unit utt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .utf8_byte (utf8_byte),
    .last_byte (last_byte)
);
